// ===== rtl/particle_lerp_update_macros.svh =====
// Assertion macros shared by the particle update checker.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef PARTICLE_LERP_UPDATE_MACROS_SVH
`define PARTICLE_LERP_UPDATE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PLU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/plu_pkg.sv =====
// Package for the particle update block: payload structs, codes and helpers.
// Depends on nothing; used by every RTL module of the block.
package plu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int SUM_W         = 68;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LIFESPAN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COLOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_COLOR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_SCALE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_X     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_Y     = 3'd6;

    // Item opcodes.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_SPAWN = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [15:0]        delta_time;
        logic signed [31:0] spawn_pos_x;
        logic signed [31:0] spawn_pos_y;
        logic signed [31:0] spawn_vel_x_start;
        logic signed [31:0] spawn_vel_x_end;
        logic signed [31:0] spawn_vel_y_start;
        logic signed [31:0] spawn_vel_y_end;
    } in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [7:0]         alpha;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [15:0]        scale;
    } out_t;

    // One product job of the shared multiplier.
    typedef enum logic [3:0] {
        JOB_DVX, JOB_DVY, JOB_VX, JOB_VY, JOB_CA, JOB_CR, JOB_CG, JOB_CB,
        JOB_SC, JOB_PX, JOB_PY
    } job_t;

    typedef struct packed {
        logic accept;
        logic prep;
        logic load;
        logic mul_lo;
        logic mul_hi;
        logic commit;
        logic div_start;
        logic div_step;
        logic out_load;
        job_t job;
    } cmd_t;

    typedef struct packed {
        logic spawn;
        logic div_done;
    } sts_t;

    // Clamp to the signed 32 bit range.
    function automatic logic signed [31:0] sat_s32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] lo;
        logic signed [SUM_W-1:0] hi;
        lo = -(SUM_W'(64'sd2147483648));
        hi = SUM_W'(64'sd2147483647);
        if (v < lo) begin
            return 32'sh8000_0000;
        end
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    // Clamp to 0..65535.
    function automatic logic [15:0] sat_u16(input logic signed [SUM_W-1:0] v);
        if (v < 0) begin
            return 16'h0000;
        end
        if (v > SUM_W'(64'sd65535)) begin
            return 16'hFFFF;
        end
        return v[15:0];
    endfunction

    // Clamp to 0..255.
    function automatic logic [7:0] sat_u8(input logic signed [SUM_W-1:0] v);
        if (v < 0) begin
            return 8'h00;
        end
        if (v > SUM_W'(64'sd255)) begin
            return 8'hFF;
        end
        return v[7:0];
    endfunction

endpackage

// ===== rtl/particle_lerp_update.sv =====
// A tick runs prep, products DVX and DVY, the divide and the other products; a spawn
// runs prep, the divide and its products. Each waits while a stalled result is offered.
// One transaction is in work at a time, so the next is taken after the result is loaded.
// The bit-serial divider and the shared 33x16 multiplier (load, low, high and commit
// per product, eleven products a tick, seven a spawn) set this order.
// Reset sets lifespan and both scales to 1.0, other settings and particle state to zero.
module particle_lerp_update #(
    parameter int FRAC_BITS = plu_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [plu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [plu_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  plu_pkg::in_t                   in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output plu_pkg::out_t                  out_data
);
    import plu_pkg::*;

    cmd_t cmd;
    sts_t sts;

    plu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    plu_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== rtl/plu_ctrl.sv =====
// Controller of the particle update block: sequences prep, divide and products.
// Depends on plu_pkg for the command and status structs.
module plu_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output plu_pkg::cmd_t cmd,
    input  plu_pkg::sts_t sts
);
    import plu_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_LOAD, ST_MLO, ST_MHI, ST_COMMIT, ST_DIV_START, ST_DIV_RUN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    job_t   job_reg;
    job_t   job_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Commands decoded from the state.
    always_comb
    begin
        cmd           = '0;
        cmd.job       = job_reg;
        cmd.accept    = (state_reg == ST_IDLE) && in_valid;
        cmd.prep      = (state_reg == ST_PREP);
        cmd.load      = (state_reg == ST_LOAD);
        cmd.mul_lo    = (state_reg == ST_MLO);
        cmd.mul_hi    = (state_reg == ST_MHI);
        cmd.commit    = (state_reg == ST_COMMIT);
        cmd.div_start = (state_reg == ST_DIV_START);
        cmd.div_step  = (state_reg == ST_DIV_RUN) && !sts.div_done;
        cmd.out_load  = (state_reg == ST_DONE) && out_free;
    end

    // Next state and job.
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (sts.spawn) begin
                    state_next = ST_DIV_START;
                end else begin
                    state_next = ST_LOAD;
                    job_next   = JOB_DVX;
                end
            end
            ST_LOAD:      state_next = ST_MLO;
            ST_MLO:       state_next = ST_MHI;
            ST_MHI:       state_next = ST_COMMIT;
            ST_COMMIT:
            begin
                state_next = ST_LOAD;
                case (job_reg)
                    JOB_DVX: job_next = JOB_DVY;
                    JOB_DVY: state_next = ST_DIV_START;
                    JOB_VX:  job_next = JOB_VY;
                    JOB_VY:  job_next = JOB_CA;
                    JOB_CA:  job_next = JOB_CR;
                    JOB_CR:  job_next = JOB_CG;
                    JOB_CG:  job_next = JOB_CB;
                    JOB_CB:  job_next = JOB_SC;
                    JOB_SC:
                    begin
                        if (sts.spawn) begin
                            state_next = ST_DONE;
                        end else begin
                            job_next = JOB_PX;
                        end
                    end
                    JOB_PX:  job_next = JOB_PY;
                    default: state_next = ST_DONE;
                endcase
            end
            ST_DIV_START: state_next = ST_DIV_RUN;
            ST_DIV_RUN:
            begin
                if (sts.div_done) begin
                    state_next = ST_LOAD;
                    job_next   = JOB_VX;
                end
            end
            ST_DONE:
            begin
                if (out_free) begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // State and registered output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            job_reg       <= JOB_DVX;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/plu_dpath.sv =====
// Datapath of the particle update block: registers, shared multiplier, divider.
// Depends on plu_pkg for payload structs, command codes and saturation helpers.
module plu_dpath #(
    parameter int FRAC_BITS = plu_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [plu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [plu_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  plu_pkg::in_t                    in_data,
    output plu_pkg::out_t                   out_data,
    input  plu_pkg::cmd_t                   cmd,
    output plu_pkg::sts_t                   sts
);
    import plu_pkg::*;

    localparam int QW    = 32 + FRAC_BITS;
    localparam int CNT_W = $clog2(QW + 1);
    localparam int UP_SH = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int DN_SH = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    // Configuration registers.
    logic [31:0]        lifespan_reg;
    logic [31:0]        start_color_reg;
    logic [31:0]        end_color_reg;
    logic [15:0]        start_scale_reg;
    logic [15:0]        end_scale_reg;
    logic signed [31:0] accel_x_reg;
    logic signed [31:0] accel_y_reg;

    // Particle state.
    logic [31:0]        age_reg;
    logic signed [31:0] posx_reg;
    logic signed [31:0] posy_reg;
    logic signed [31:0] vxf_reg;
    logic signed [31:0] vxt_reg;
    logic signed [31:0] vyf_reg;
    logic signed [31:0] vyt_reg;

    // Working registers.
    in_t                item_reg;
    logic [32:0]        mag_reg;
    logic [32:0]        mag_next;
    logic               neg_reg;
    logic [31:0]        mulm_reg;
    logic [31:0]        mulm_next;
    logic               shfrac_reg;
    logic               shfrac_next;
    logic [64:0]        acc_reg;
    logic [31:0]        rem_reg;
    logic [31:0]        rem_next;
    logic [QW-1:0]      quo_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic signed [31:0] vx_reg;
    logic signed [31:0] vy_reg;
    logic [7:0]         ca_reg;
    logic [7:0]         cr_reg;
    logic [7:0]         cg_reg;
    logic [7:0]         cb_reg;
    logic [15:0]        sc_reg;
    out_t               out_reg;

    logic signed [33:0] diff;
    logic signed [33:0] diff_abs;
    logic [48:0]        prod;
    logic [64:0]        shifted;
    logic signed [65:0] res;
    logic signed [SUM_W-1:0] res_ext;
    logic [32:0]        dta;
    logic [32:0]        age_sum;
    logic [31:0]        divisor;
    logic [32:0]        trial;
    logic               ge;
    logic [31:0]        ratio;
    logic [7:0]         s_ch;
    logic [7:0]         e_ch;

    // Ratio saturates when the quotient leaves 32 bits.
    assign ratio   = (|quo_reg[QW-1:32]) ? 32'hFFFF_FFFF : quo_reg[31:0];
    assign divisor = (lifespan_reg == 32'd0) ? 32'd1 : lifespan_reg;

    // Restoring divider step.
    assign trial    = {rem_reg, quo_reg[QW-1]};
    assign ge       = (trial >= {1'b0, divisor});
    assign rem_next = ge ? 32'(trial - {1'b0, divisor}) : trial[31:0];

    assign sts.spawn    = (item_reg.opcode == OP_SPAWN);
    assign sts.div_done = (cnt_reg == '0);

    // Age increment in the age format.
    assign dta     = ({17'd0, item_reg.delta_time} << UP_SH) >> DN_SH;
    assign age_sum = {1'b0, age_reg} + dta;

    // Color channel of the current job.
    always_comb
    begin
        case (cmd.job)
            JOB_CA:
            begin
                s_ch = start_color_reg[31:24];
                e_ch = end_color_reg[31:24];
            end
            JOB_CR:
            begin
                s_ch = start_color_reg[23:16];
                e_ch = end_color_reg[23:16];
            end
            JOB_CG:
            begin
                s_ch = start_color_reg[15:8];
                e_ch = end_color_reg[15:8];
            end
            default:
            begin
                s_ch = start_color_reg[7:0];
                e_ch = end_color_reg[7:0];
            end
        endcase
    end

    // Operand select for the multiplier.
    always_comb
    begin
        diff        = '0;
        mulm_next   = ratio;
        shfrac_next = 1'b1;
        case (cmd.job)
            JOB_DVX:
            begin
                diff        = 34'(accel_x_reg);
                mulm_next   = {16'd0, item_reg.delta_time};
                shfrac_next = 1'b0;
            end
            JOB_DVY:
            begin
                diff        = 34'(accel_y_reg);
                mulm_next   = {16'd0, item_reg.delta_time};
                shfrac_next = 1'b0;
            end
            JOB_VX:  diff = 34'(vxt_reg) - 34'(vxf_reg);
            JOB_VY:  diff = 34'(vyt_reg) - 34'(vyf_reg);
            JOB_CA, JOB_CR, JOB_CG, JOB_CB:
            begin
                diff = 34'(signed'({1'b0, e_ch})) - 34'(signed'({1'b0, s_ch}));
            end
            JOB_SC:
            begin
                diff = 34'(signed'({1'b0, end_scale_reg}))
                     - 34'(signed'({1'b0, start_scale_reg}));
            end
            JOB_PX:
            begin
                diff        = 34'(vx_reg);
                mulm_next   = {16'd0, item_reg.delta_time};
                shfrac_next = 1'b0;
            end
            default:
            begin
                diff        = 34'(vy_reg);
                mulm_next   = {16'd0, item_reg.delta_time};
                shfrac_next = 1'b0;
            end
        endcase
        diff_abs = diff[33] ? -diff : diff;
        mag_next = diff_abs[32:0];
    end

    // Shared 33x16 multiplier, low chunk then high chunk of the multiplicand.
    assign prod = mag_reg * (cmd.mul_hi ? mulm_reg[31:16] : mulm_reg[15:0]);

    // Truncate toward zero and restore the sign.
    assign shifted = shfrac_reg ? (acc_reg >> FRAC_BITS) : (acc_reg >> 16);
    assign res     = neg_reg ? -$signed({1'b0, shifted}) : $signed({1'b0, shifted});
    assign res_ext = SUM_W'(res);

    // Configuration and particle state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lifespan_reg    <= 32'd65536;
            start_color_reg <= '0;
            end_color_reg   <= '0;
            start_scale_reg <= 16'd256;
            end_scale_reg   <= 16'd256;
            accel_x_reg     <= '0;
            accel_y_reg     <= '0;
            age_reg         <= '0;
            posx_reg        <= '0;
            posy_reg        <= '0;
            vxf_reg         <= '0;
            vxt_reg         <= '0;
            vyf_reg         <= '0;
            vyt_reg         <= '0;
            cnt_reg         <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LIFESPAN:    lifespan_reg    <= cfg_data;
                    CFG_START_COLOR: start_color_reg <= cfg_data;
                    CFG_END_COLOR:   end_color_reg   <= cfg_data;
                    CFG_START_SCALE: start_scale_reg <= cfg_data[15:0];
                    CFG_END_SCALE:   end_scale_reg   <= cfg_data[15:0];
                    CFG_ACCEL_X:     accel_x_reg     <= cfg_data;
                    CFG_ACCEL_Y:     accel_y_reg     <= cfg_data;
                    default:         ;
                endcase
            end
            if (cmd.prep) begin
                if (item_reg.opcode == OP_SPAWN) begin
                    posx_reg <= item_reg.spawn_pos_x;
                    posy_reg <= item_reg.spawn_pos_y;
                    vxf_reg  <= item_reg.spawn_vel_x_start;
                    vxt_reg  <= item_reg.spawn_vel_x_end;
                    vyf_reg  <= item_reg.spawn_vel_y_start;
                    vyt_reg  <= item_reg.spawn_vel_y_end;
                    age_reg  <= '0;
                end else begin
                    age_reg <= age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
                end
            end
            if (cmd.commit) begin
                case (cmd.job)
                    JOB_DVX:
                    begin
                        vxf_reg <= sat_s32(SUM_W'(vxf_reg) + res_ext);
                        vxt_reg <= sat_s32(SUM_W'(vxt_reg) + res_ext);
                    end
                    JOB_DVY:
                    begin
                        vyf_reg <= sat_s32(SUM_W'(vyf_reg) + res_ext);
                        vyt_reg <= sat_s32(SUM_W'(vyt_reg) + res_ext);
                    end
                    JOB_PX:  posx_reg <= sat_s32(SUM_W'(posx_reg) + res_ext);
                    JOB_PY:  posy_reg <= sat_s32(SUM_W'(posy_reg) + res_ext);
                    default: ;
                endcase
            end
            if (cmd.div_start) begin
                cnt_reg <= CNT_W'(QW);
            end else if (cmd.div_step) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept) begin
            item_reg <= in_data;
        end
        if (cmd.load) begin
            mag_reg    <= mag_next;
            neg_reg    <= diff[33];
            mulm_reg   <= mulm_next;
            shfrac_reg <= shfrac_next;
        end
        if (cmd.mul_lo) begin
            acc_reg <= 65'(prod);
        end
        if (cmd.mul_hi) begin
            acc_reg <= acc_reg + {prod, 16'd0};
        end
        if (cmd.div_start) begin
            rem_reg <= '0;
            quo_reg <= {age_reg, {FRAC_BITS{1'b0}}};
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QW-2:0], ge};
        end
        if (cmd.commit) begin
            case (cmd.job)
                JOB_VX:  vx_reg <= sat_s32(SUM_W'(vxf_reg) + res_ext);
                JOB_VY:  vy_reg <= sat_s32(SUM_W'(vyf_reg) + res_ext);
                JOB_CA, JOB_CR, JOB_CG, JOB_CB:
                begin
                    case (cmd.job)
                        JOB_CA:  ca_reg <= sat_u8(SUM_W'(signed'({1'b0, s_ch})) + res_ext);
                        JOB_CR:  cr_reg <= sat_u8(SUM_W'(signed'({1'b0, s_ch})) + res_ext);
                        JOB_CG:  cg_reg <= sat_u8(SUM_W'(signed'({1'b0, s_ch})) + res_ext);
                        default: cb_reg <= sat_u8(SUM_W'(signed'({1'b0, s_ch})) + res_ext);
                    endcase
                end
                JOB_SC:
                begin
                    sc_reg <= sat_u16(SUM_W'(signed'({1'b0, start_scale_reg})) + res_ext);
                end
                default: ;
            endcase
        end
        if (cmd.out_load) begin
            out_reg.pos_x <= posx_reg;
            out_reg.pos_y <= posy_reg;
            out_reg.vel_x <= vx_reg;
            out_reg.vel_y <= vy_reg;
            out_reg.alpha <= ca_reg;
            out_reg.red   <= cr_reg;
            out_reg.green <= cg_reg;
            out_reg.blue  <= cb_reg;
            out_reg.scale <= sc_reg;
        end
    end

    assign out_data = out_reg;

endmodule

// ===== rtl/plu_checker.sv =====
// Port-level checker for the particle update block, bound to the top level.
// Depends on plu_pkg and particle_lerp_update_macros.svh.
`include "particle_lerp_update_macros.svh"

module plu_assert (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_stall,
    input plu_pkg::in_t  in_data,
    input logic          out_valid,
    input logic          out_stall,
    input plu_pkg::out_t out_data
);
    import plu_pkg::*;

    // A stalled result stays offered and unchanged.
    `PLU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped")
    `PLU_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data), "result changed")

    // A stalled input payload stays unchanged.
    `PLU_ASSERT_NEXT(a_in_stable, in_valid && in_stall, $stable(in_data), "input changed")

    // One transaction at a time: the input closes right after an accept.
    `PLU_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second transaction taken")

    // A new result only appears while a transaction is in work.
    `PLU_ASSERT_NOW(a_out_src, $rose(out_valid), $past(in_stall), "result without work")

endmodule

bind particle_lerp_update plu_assert u_plu_checker (.*);

// ===== dv/plu_checker.sv =====
// Checker for the particle update block: watches both channels, predicts each
// result from the accepted transactions and register writes, and counts mismatches.
// Depends on plu_pkg for the payload structs and register indexes.
module plu_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [plu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [plu_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  plu_pkg::in_t                   in_data,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  plu_pkg::out_t                  out_data,
    output int                             errors,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import plu_pkg::*;

    localparam int FB = 16;

    // Shadow registers and particle state.
    logic [31:0]        life_r, col_a, col_b;
    logic [15:0]        scl_a, scl_b;
    logic signed [31:0] acc_x, acc_y;
    logic [31:0]        p_age;
    logic signed [31:0] p_x, p_y, vx0, vx1, vy0, vy1;

    out_t particle_q[$];

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Product truncated toward zero.
    function automatic longint scaled(longint d, longint m, int sh);
        longint unsigned mag;
        mag = d < 0 ? -d : d;
        mag = (mag * longint'(m)) >> sh;
        return d < 0 ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint mix(longint a, longint b, logic [31:0] r);
        return a + scaled(b - a, longint'({32'd0, r}), FB);
    endfunction

    // Advance the particle by one transaction and return the expected result.
    task automatic advance(input in_t it, output out_t res);
        longint dt, na, dvx, dvy, q, lo32, hi32;
        longint unsigned dv;
        logic [31:0] ratio;
        lo32 = -64'sd2147483648;
        hi32 = 64'sd2147483647;
        dt = longint'({48'd0, it.delta_time});
        if (it.opcode == OP_SPAWN) begin
            p_x = it.spawn_pos_x; p_y = it.spawn_pos_y;
            vx0 = it.spawn_vel_x_start; vx1 = it.spawn_vel_x_end;
            vy0 = it.spawn_vel_y_start; vy1 = it.spawn_vel_y_end;
            p_age = '0;
        end else begin
            na = longint'({32'd0, p_age}) + (dt << (FB - 16));
            p_age = na > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : na[31:0];
            dvx = scaled(acc_x, dt, 16);
            dvy = scaled(acc_y, dt, 16);
            vx0 = 32'(clamp(vx0 + dvx, lo32, hi32));
            vx1 = 32'(clamp(vx1 + dvx, lo32, hi32));
            vy0 = 32'(clamp(vy0 + dvy, lo32, hi32));
            vy1 = 32'(clamp(vy1 + dvy, lo32, hi32));
        end
        // Zero lifespan divides by the smallest step.
        dv = life_r == 0 ? 1 : {32'd0, life_r};
        q = longint'(({32'd0, p_age} << FB) / dv);
        ratio = q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
        res.vel_x = 32'(clamp(mix(vx0, vx1, ratio), lo32, hi32));
        res.vel_y = 32'(clamp(mix(vy0, vy1, ratio), lo32, hi32));
        if (it.opcode == OP_TICK) begin
            p_x = 32'(clamp(p_x + scaled(res.vel_x, dt, 16), lo32, hi32));
            p_y = 32'(clamp(p_y + scaled(res.vel_y, dt, 16), lo32, hi32));
        end
        res.pos_x = p_x;
        res.pos_y = p_y;
        res.alpha = 8'(clamp(mix(col_a[31:24], col_b[31:24], ratio), 0, 255));
        res.red   = 8'(clamp(mix(col_a[23:16], col_b[23:16], ratio), 0, 255));
        res.green = 8'(clamp(mix(col_a[15:8], col_b[15:8], ratio), 0, 255));
        res.blue  = 8'(clamp(mix(col_a[7:0], col_b[7:0], ratio), 0, 255));
        res.scale = 16'(clamp(mix(scl_a, scl_b, ratio), 0, 65535));
    endtask

    assign pending = particle_q.size();

    // Track register writes, predict on input transactions, compare outputs.
    always @(posedge clk or negedge rst_n)
    begin
        out_t want, got;
        if (!rst_n)
        begin
            life_r = 32'h0001_0000; col_a = '0; col_b = '0;
            scl_a = 16'd256; scl_b = 16'd256; acc_x = '0; acc_y = '0;
            p_age = '0; p_x = '0; p_y = '0; vx0 = '0; vx1 = '0; vy0 = '0; vy1 = '0;
            errors = 0;
            particle_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LIFESPAN:    life_r = cfg_data;
                    CFG_START_COLOR: col_a = cfg_data;
                    CFG_END_COLOR:   col_b = cfg_data;
                    CFG_START_SCALE: scl_a = cfg_data[15:0];
                    CFG_END_SCALE:   scl_b = cfg_data[15:0];
                    CFG_ACCEL_X:     acc_x = cfg_data;
                    CFG_ACCEL_Y:     acc_y = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                advance(in_data, want);
                particle_q.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                got = out_data;
                if (particle_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transaction %h", $realtime, got);
                end
                else
                begin
                    want = particle_q.pop_front();
                    if (got.pos_x !== want.pos_x)
                    begin
                        errors++;
                        $display("%0t: pos_x exp %h got %h", $realtime, want.pos_x, got.pos_x);
                    end
                    if (got.pos_y !== want.pos_y)
                    begin
                        errors++;
                        $display("%0t: pos_y exp %h got %h", $realtime, want.pos_y, got.pos_y);
                    end
                    if (got.vel_x !== want.vel_x)
                    begin
                        errors++;
                        $display("%0t: vel_x exp %h got %h", $realtime, want.vel_x, got.vel_x);
                    end
                    if (got.vel_y !== want.vel_y)
                    begin
                        errors++;
                        $display("%0t: vel_y exp %h got %h", $realtime, want.vel_y, got.vel_y);
                    end
                    if (got.alpha !== want.alpha)
                    begin
                        errors++;
                        $display("%0t: alpha exp %h got %h", $realtime, want.alpha, got.alpha);
                    end
                    if (got.red !== want.red)
                    begin
                        errors++;
                        $display("%0t: red exp %h got %h", $realtime, want.red, got.red);
                    end
                    if (got.green !== want.green)
                    begin
                        errors++;
                        $display("%0t: green exp %h got %h", $realtime, want.green, got.green);
                    end
                    if (got.blue !== want.blue)
                    begin
                        errors++;
                        $display("%0t: blue exp %h got %h", $realtime, want.blue, got.blue);
                    end
                    if (got.scale !== want.scale)
                    begin
                        errors++;
                        $display("%0t: scale exp %h got %h", $realtime, want.scale, got.scale);
                    end
                end
            end
        end
    end
endmodule

// ===== dv/tb_top.sv =====
// Top of the particle update testbench: clock, reset, register phases, stimulus
// and verdict. Depends on plu_pkg, plu_checker and the particle_lerp_update RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import plu_pkg::*;

    localparam int TIMEOUT = 2000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_LIFESPAN;
    logic [31:0]          cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_t                  in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_t                 out_data;
    int                   errors, pending;
    bit                   calm = 1'b0;
    bit                   hold_long = 1'b0;
    int                   quiet = 0;

    always #6 clk = ~clk;

    particle_lerp_update uut (.*);

    plu_checker chk (.*);

    // Receiver: random stall bursts, one long hold-off on request, none at the end.
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                out_stall <= 1'b1;
                repeat (600) @(posedge clk);
                hold_long = 1'b0;
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 7);
                out_stall <= 1'b1;
                repeat (n - 1) @(posedge clk);
                @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > TIMEOUT)
        begin
            $display("[particle_lerp_update] ERROR");
            $finish;
        end
    end

    // One register write; the write enable is low again when the task returns.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one transaction and hold it until accepted, with optional idle burst first.
    task automatic send(input in_t it);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    function automatic in_t rand_item(bit spawn_bias);
        in_t it;
        it = $bits(in_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom});
        it.opcode = spawn_bias ? OP_SPAWN : OP_TICK;
        case ($urandom_range(0, 3))
            0: it.delta_time = 16'($urandom_range(0, 255));
            1: it.delta_time = 16'hFFFF;
            default: it.delta_time = 16'($urandom);
        endcase
        if ($urandom_range(0, 2) != 0)
        begin
            it.spawn_vel_x_start = $signed($urandom) >>> $urandom_range(8, 20);
            it.spawn_vel_x_end   = $signed($urandom) >>> $urandom_range(8, 20);
            it.spawn_vel_y_start = $signed($urandom) >>> $urandom_range(8, 20);
            it.spawn_vel_y_end   = $signed($urandom) >>> $urandom_range(8, 20);
        end
        return it;
    endfunction

    // Wait for the block to drain before touching registers.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (110) @(posedge clk);
    endtask

    task automatic random_settings();
        write_reg(CFG_LIFESPAN, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 32'h4_0000));
        write_reg(CFG_START_COLOR, $urandom);
        write_reg(CFG_END_COLOR, $urandom);
        write_reg(CFG_START_SCALE, $urandom);
        write_reg(CFG_END_SCALE, $urandom);
        write_reg(CFG_ACCEL_X, $signed($urandom) >>> $urandom_range(0, 16));
        write_reg(CFG_ACCEL_Y, $signed($urandom) >>> $urandom_range(0, 16));
    endtask

    initial
    begin
        in_t it;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, spawn and plain ticks.
        it = '0;
        it.opcode = OP_SPAWN;
        it.delta_time = 16'hFFFF;
        it.spawn_pos_x = 32'sh0001_0000; it.spawn_vel_x_start = 32'sh0002_0000;
        it.spawn_vel_x_end = -32'sh0002_0000; it.spawn_vel_y_end = 32'sh0010_0000;
        send(it);
        it.opcode = OP_TICK;
        it.delta_time = 16'h0000; send(it);
        it.delta_time = 16'h8000; send(it);
        it.delta_time = 16'hFFFF; send(it);
        it.delta_time = 16'hFFFF; send(it);
        drain();

        // Extreme settings: zero lifespan, full colors, maximal accelerations.
        write_reg(CFG_LIFESPAN, 32'd0);
        write_reg(CFG_START_COLOR, 32'h00FF_00FF);
        write_reg(CFG_END_COLOR, 32'hFF00_FF00);
        write_reg(CFG_START_SCALE, 32'h0000_0000);
        write_reg(CFG_END_SCALE, 32'h0000_FFFF);
        write_reg(CFG_ACCEL_X, 32'h7FFF_FFFF);
        write_reg(CFG_ACCEL_Y, 32'h8000_0000);
        it = '0;
        it.opcode = OP_SPAWN;
        it.spawn_pos_x = 32'sh7FFF_FFFF; it.spawn_pos_y = 32'sh8000_0000;
        it.spawn_vel_x_start = 32'sh7FFF_FFFF; it.spawn_vel_x_end = 32'sh8000_0000;
        it.spawn_vel_y_start = 32'sh8000_0000; it.spawn_vel_y_end = 32'sh7FFF_FFFF;
        send(it);
        it.opcode = OP_TICK;
        it.delta_time = 16'h0001; send(it);
        it.delta_time = 16'hFFFF; send(it); send(it);
        drain();

        // Max lifespan, followed by four long ticks.
        write_reg(CFG_LIFESPAN, 32'hFFFF_FFFF);
        write_reg(CFG_ACCEL_X, 32'h0000_0000);
        write_reg(CFG_ACCEL_Y, 32'h0000_0001);
        it.opcode = OP_TICK;
        it.delta_time = 16'hFFFF;
        repeat (4) send(it);
        drain();

        // Long receiver hold-off while the sender keeps offering.
        hold_long = 1'b1;
        repeat (6) send(rand_item($urandom_range(0, 5) == 0));
        drain();

        // Random phases: spawns followed by runs of ticks.
        for (int ph = 0; ph < 8; ph++)
        begin
            random_settings();
            if (ph == 7) calm = 1'b1;
            for (int k = 0; k < 110; k++)
                send(rand_item($urandom_range(0, 9) == 0));
            drain();
        end

        if (errors == 0)
            $display("[particle_lerp_update] OK");
        else
            $display("[particle_lerp_update] ERROR");
        $finish;
    end
endmodule
